// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	// queue depth and derived widths
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	// result status codes
	localparam logic [1:0] STS_INSERTED = 2'd0;
	localparam logic [1:0] STS_POPPED   = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;
	localparam logic [1:0] STS_DROPPED  = 2'd3;

	// operation codes of the kind field
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;
		logic pop;
	} spq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} spq_stat_t;

endpackage

// ===== hdl/spq_datapath.sv =====
module spq_datapath import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_cmd_t                 cmd,
	input  logic signed [DATA_W-1:0] new_value,
	input  logic signed [DATA_W-1:0] new_priority,
	output spq_stat_t                stat,
	output logic signed [DATA_W-1:0] head_value
);

	logic signed [DATA_W-1:0] val_q [CAPACITY];
	logic signed [DATA_W-1:0] pri_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic [CAPACITY-1:0]      ge;

	assign stat.full  = (count_q == CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);
	assign head_value = val_q[0];

	// each cell compares its own priority against the new entry
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (pri_q[i] >= new_priority);
		end
	end

	// sorted cell row: hold, take the new entry, or shift
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.insert && !ge[i]) begin
				if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
					val_q[i] <= new_value;
					pri_q[i] <= new_priority;
				end else begin
					val_q[i] <= val_q[(i == 0) ? 0 : i - 1];
					pri_q[i] <= pri_q[(i == 0) ? 0 : i - 1];
				end
			end else if (cmd.pop && i < CAPACITY - 1) begin
				val_q[i] <= val_q[(i < CAPACITY - 1) ? i + 1 : i];
				pri_q[i] <= pri_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     kind,
	output logic                     busy,
	output spq_cmd_t                 cmd,
	input  spq_stat_t                stat,
	input  logic signed [DATA_W-1:0] head_value,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] popped_value,
	output logic [1:0]               status
);

	typedef enum logic [1:0] {
		ST_RESET = 2'b01,
		ST_READY = 2'b10
	} state_t;

	state_t                   state_q;
	logic                     accept;
	logic                     strobe_q;
	logic signed [DATA_W-1:0] value_q;
	logic [1:0]               status_q;

	// busy only in the cycle right after reset
	assign busy   = (state_q != ST_READY);
	assign accept = start && !busy;

	// decode the accepted word into datapath commands
	assign cmd.insert = accept && (kind == KIND_INSERT) && !stat.full;
	assign cmd.pop    = accept && (kind == KIND_POP) && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RESET;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= accept;
			case (state_q)
				ST_RESET: state_q <= ST_READY;
				ST_READY: state_q <= ST_READY;
				default:  state_q <= ST_RESET;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind == KIND_INSERT) begin
				value_q  <= '0;
				status_q <= stat.full ? STS_DROPPED : STS_INSERTED;
			end else if (stat.empty) begin
				value_q  <= -DATA_W'(1);
				status_q <= STS_EMPTY;
			end else begin
				value_q  <= head_value;
				status_q <= STS_POPPED;
			end
		end
	end

	assign strobe       = strobe_q;
	assign popped_value = value_q;
	assign status       = status_q;

endmodule

// ===== hdl/stable_priority_queue.sv =====
// stable priority queue of CAPACITY entries, sorted highest priority first
// input channel: a word (kind, item_value, item_priority) is taken at a rising
// edge where start is high and busy is low; kind 0 inserts, kind 1 pops
// an insert goes behind every stored entry of equal or higher priority, so
// equal priorities leave in arrival order
// output channel: every accepted word gives one result word, shown on
// popped_value and status for exactly one cycle with strobe high, the cycle
// after the word was taken
// throughput: one word per cycle once busy is low; each entry is a cell
// with its own comparator, and the whole row holds, loads or shifts at once
// status: 0 inserted, 1 popped, 2 pop on empty (value -1), 3 insert dropped
// because full; inserts return value 0
// reset empties the queue; busy is high for the first cycle after reset
// the receiver cannot stall: results are never held back
module stable_priority_queue import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] popped_value,
	output logic [1:0]               status
);

	spq_cmd_t                 cmd;
	spq_stat_t                stat;
	logic signed [DATA_W-1:0] head_value;

	// sequencing and result word
	spq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.busy         (busy),
		.cmd          (cmd),
		.stat         (stat),
		.head_value   (head_value),
		.strobe       (strobe),
		.popped_value (popped_value),
		.status       (status)
	);

	// sorted entry store
	spq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.new_value    (item_value),
		.new_priority (item_priority),
		.stat         (stat),
		.head_value   (head_value)
	);

endmodule

// ===== dv/spq_checker.sv =====
`timescale 1ns / 100ps

module spq_checker import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	input  logic                     strobe,
	input  logic signed [DATA_W-1:0] popped_value,
	input  logic [1:0]               status,
	output int                       error_count,
	output int                       pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [1:0]               status;
	} queue_result_t;

	// shadow copy of the sorted queue, head at index 0
	logic signed [DATA_W-1:0] shadow_value [CAPACITY];
	logic signed [DATA_W-1:0] shadow_prio  [CAPACITY];
	int                       shadow_count;

	queue_result_t awaited_results[$];
	int            mismatches;
	int            outstanding;

	assign error_count = mismatches;
	assign pending     = outstanding;

	// apply one word to the shadow queue and return the result it should give
	function automatic queue_result_t apply_queue_word(logic op,
			logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] pri);
		queue_result_t r;
		int            slot;
		if (op == KIND_INSERT) begin
			r.value = '0;
			if (shadow_count >= CAPACITY) begin
				r.status = STS_DROPPED;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				slot = 0;
				while (slot < shadow_count && shadow_prio[slot] >= pri)
					slot++;
				for (int i = shadow_count; i > slot; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_prio[i]  = shadow_prio[i-1];
				end
				shadow_value[slot] = val;
				shadow_prio[slot]  = pri;
				shadow_count++;
				r.status = STS_INSERTED;
			end
		end else if (shadow_count == 0) begin
			r.value  = '1;
			r.status = STS_EMPTY;
		end else begin
			r.value = shadow_value[0];
			for (int i = 1; i < shadow_count; i++) begin
				shadow_value[i-1] = shadow_value[i];
				shadow_prio[i-1]  = shadow_prio[i];
			end
			shadow_count--;
			r.status = STS_POPPED;
		end
		return r;
	endfunction

	// compare results first, then take the new word, since a word's result shows in the cycle after it is taken
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			shadow_count = 0;
			awaited_results.delete();
			outstanding = 0;
			mismatches  = 0;
		end else begin
			if (strobe === 1'b1) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with nothing awaited: value %0d status %0d",
							$realtime, popped_value, status);
				end else begin
					want = awaited_results.pop_front();
					if (popped_value !== want.value || status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: value exp %0d got %0d, status exp %0d got %0d",
								$realtime, want.value, popped_value, want.status, status);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				awaited_results.push_back(apply_queue_word(kind, item_value, item_priority));
			outstanding = awaited_results.size();
		end
	end

endmodule

// ===== dv/stable_priority_queue_test.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_test;
	import spq_pkg::*;

	localparam int PHASE_WORDS = 200;
	localparam int CYCLE_LIMIT = 200000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     kind;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_priority;
	logic                     strobe;
	logic signed [DATA_W-1:0] popped_value;
	logic [1:0]               status;
	int                       error_count;
	int                       pending;
	int                       cycles;

	stable_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.item_value    (item_value),
		.item_priority (item_priority),
		.strobe        (strobe),
		.popped_value  (popped_value),
		.status        (status)
	);

	spq_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.item_value    (item_value),
		.item_priority (item_priority),
		.strobe        (strobe),
		.popped_value  (popped_value),
		.status        (status),
		.error_count   (error_count),
		.pending       (pending)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// values: mostly random, sometimes the extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// priorities: a narrow band for ties, the extremes, and full range
	function automatic logic signed [DATA_W-1:0] pick_priority();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return int'($urandom_range(4)) - 2;
		if (roll < 50) begin
			case ($urandom_range(3))
				0: return 32'sh7fffffff;
				1: return 32'sh7ffffffe;
				2: return 32'sh80000000;
				default: return 32'sh80000001;
			endcase
		end
		return $urandom;
	endfunction

	// hold a word on the inputs until the block takes it
	task automatic issue_word(logic op, logic signed [DATA_W-1:0] val,
			logic signed [DATA_W-1:0] pri);
		@(negedge clk);
		start         <= 1'b1;
		kind          <= op;
		item_value    <= val;
		item_priority <= pri;
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
	endtask

	task automatic idle_gaps(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	initial begin
		int idle_pct [3];
		int insert_pct [4];
		int seg_lo [4];
		int seg_hi [4];
		int sent;
		int seg;
		int seg_len;
		logic op;

		// sender idle rate per phase
		idle_pct = '{21, 72, 0};
		// segment shapes: fill, mixed, drain, mixed
		insert_pct = '{95, 50, 5, 50};
		seg_lo     = '{70, 10, 70, 10};
		seg_hi     = '{100, 40, 100, 40};

		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = KIND_INSERT;
		item_value    = '0;
		item_priority = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, extremes, ties, drain back to empty
		issue_word(KIND_POP, pick_value(), pick_priority());
		issue_word(KIND_INSERT, 32'sh7fffffff, 32'sh7fffffff);
		issue_word(KIND_INSERT, 32'sh80000000, 32'sh80000000);
		issue_word(KIND_INSERT, -32'sd1, 32'sd0);
		issue_word(KIND_INSERT, 32'sd0, 32'sd0);
		issue_word(KIND_INSERT, 32'sd1, 32'sd0);
		issue_word(KIND_INSERT, 32'sd2, 32'sh7fffffff);
		issue_word(KIND_INSERT, 32'sd3, 32'sh80000000);
		issue_word(KIND_INSERT, 32'sd4, -32'sd1);
		repeat (8)
			issue_word(KIND_POP, pick_value(), pick_priority());
		issue_word(KIND_POP, 32'sh7fffffff, 32'sh7fffffff);
		issue_word(KIND_INSERT, 32'sd5, 32'sd1);
		issue_word(KIND_POP, 32'sh80000000, 32'sh80000000);
		issue_word(KIND_POP, '0, '0);

		// random: alternating fill and drain runs so full and empty both occur
		for (int phase = 0; phase < 3; phase++) begin
			sent = 0;
			seg  = 0;
			while (sent < PHASE_WORDS) begin
				seg_len = $urandom_range(seg_hi[seg], seg_lo[seg]);
				for (int j = 0; j < seg_len && sent < PHASE_WORDS; j++) begin
					op = ($urandom_range(99) < insert_pct[seg]) ? KIND_INSERT : KIND_POP;
					idle_gaps(idle_pct[phase]);
					issue_word(op, pick_value(), pick_priority());
					sent++;
				end
				seg = (seg + 1) % 4;
			end
		end

		@(negedge clk);
		start <= 1'b0;

		// drain the remaining results, then idle before the final check
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
